// ----- design/hpe_pkg.sv -----
package hpe_pkg;

	// command codes
	localparam logic [2:0] CMD_LOAD_POINT = 3'd0;
	localparam logic [2:0] CMD_LOAD_DU    = 3'd1;
	localparam logic [2:0] CMD_LOAD_DV    = 3'd2;
	localparam logic [2:0] CMD_LOAD_NRM   = 3'd3;
	localparam logic [2:0] CMD_EVAL_POINT = 3'd4;
	localparam logic [2:0] CMD_EVAL_DU    = 3'd5;
	localparam logic [2:0] CMD_EVAL_DV    = 3'd6;

	localparam int CMD_W       = 3;
	localparam int CORNER_W    = 2;
	localparam int PARAM_W     = 17;
	localparam int PARAM_FRAC  = 16;
	localparam int WEIGHT_FRAC = 30;
	localparam int WGT_SHIFT   = 3 * PARAM_FRAC - WEIGHT_FRAC;
	localparam int WGT_W       = 32;
	localparam int SQ_W        = 2 * PARAM_W - 1;
	localparam int CUBE_W      = 3 * PARAM_W - 2;
	localparam int BASIS_W     = 56;
	localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC;

	// Entries of the 4x4 geometry matrix that are not zero (twists are zero).
	localparam int NUM_ENT = 12;
	localparam int ENT_W   = 4;
	localparam logic [1:0] ENT_I [NUM_ENT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2,
		2'd3, 2'd3, 2'd0, 2'd0, 2'd1, 2'd1};
	localparam logic [1:0] ENT_J [NUM_ENT] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1,
		2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3};
	localparam logic       ENT_TAN [NUM_ENT] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
		1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
	localparam logic [1:0] ENT_CRN [NUM_ENT] = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1,
		2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2};
	localparam logic       ENT_DIR [NUM_ENT] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

	typedef logic [3:0][WGT_W-1:0] wgt4_t;

endpackage

// ----- design/hermite_patch_evaluator.sv -----
// Channel   Dir  Payload                                          Note
// s_axis    in   tuser: command, corner; tdata: x, y, z, u, v     load or evaluate request
// m_axis    out  tdata: out_x, out_y, out_z                       one per evaluate request
//
// Ten register stages; one request enters per cycle while s_axis_tready is high.
// An evaluate result leaves from stage ten; loads write the corner store at once
// and produce nothing. Stages: parameter clamp, snapshot and d.n products, dot,
// dot*n, tangent, v-weighting, split u-weighting, recombine, two adder levels.
// Reset clears all valid bits; the corner store holds garbage until loaded.
// A stalled output holds stage ten; earlier stages keep moving into empty slots.
module hermite_patch_evaluator #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// command [2:0], corner [4:3]
	input  logic [hpe_pkg::CMD_W+hpe_pkg::CORNER_W-1:0] s_axis_tuser,
	// vec_x, vec_y, vec_z, param_u, param_v, zero pad
	input  logic [((3*COORD_WIDTH+2*hpe_pkg::PARAM_W+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_x, out_y, out_z, zero pad
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

	localparam int CW    = COORD_WIDTH;
	localparam int PW2   = 2 * CW;
	localparam int ACC_W = 2 * CW + FRAC_BITS + 2;
	localparam int PW    = CW + hpe_pkg::WGT_W;
	localparam int LO_W  = 32;
	localparam int PL_W  = hpe_pkg::WGT_W + LO_W + 1;
	localparam int SUMW  = CW + 2 * hpe_pkg::WEIGHT_FRAC + 10;
	localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
	localparam int NE    = hpe_pkg::NUM_ENT;
	localparam int PU    = hpe_pkg::PARAM_W;

	localparam logic signed [ACC_W-1:0] AMAX = ACC_W'({(CW-1){1'b1}});
	localparam logic signed [ACC_W-1:0] AMIN = -AMAX - ACC_W'(1);
	localparam logic signed [SUMW-1:0]  SMAX = SUMW'({(CW-1){1'b1}});
	localparam logic signed [SUMW-1:0]  SMIN = -SMAX - SUMW'(1);

	// floor by 2^FRAC_BITS, saturate
	function automatic logic signed [CW-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] sh;
		sh = a >>> FRAC_BITS;
		if (sh > AMAX) return CW'(AMAX);
		else if (sh < AMIN) return CW'(AMIN);
		else return sh[CW-1:0];
	endfunction

	// floor by 2^(2*WEIGHT_FRAC), saturate
	function automatic logic signed [CW-1:0] sat_sum(input logic signed [SUMW-1:0] a);
		logic signed [SUMW-1:0] sh;
		sh = a >>> (2 * hpe_pkg::WEIGHT_FRAC);
		if (sh > SMAX) return CW'(SMAX);
		else if (sh < SMIN) return CW'(SMIN);
		else return sh[CW-1:0];
	endfunction

	// Hermite basis or its derivative in Q48, floored to Q30
	function automatic hpe_pkg::wgt4_t basis(input logic [PU-1:0] t,
		input logic [hpe_pkg::SQ_W-1:0] t2, input logic [hpe_pkg::CUBE_W-1:0] t3,
		input logic deriv);
		logic signed [hpe_pkg::BASIS_W-1:0] a1, a2, a3, one;
		logic signed [hpe_pkg::BASIS_W-1:0] q [4];
		hpe_pkg::wgt4_t w;
		a1  = hpe_pkg::BASIS_W'(t) <<< (2 * hpe_pkg::PARAM_FRAC);
		a2  = hpe_pkg::BASIS_W'(t2) <<< hpe_pkg::PARAM_FRAC;
		a3  = hpe_pkg::BASIS_W'(t3);
		one = hpe_pkg::BASIS_W'(1) <<< (3 * hpe_pkg::PARAM_FRAC);
		if (!deriv) begin
			q[0] = 2 * a3 - 3 * a2 + one;
			q[1] = -2 * a3 + 3 * a2;
			q[2] = a3 - 2 * a2 + a1;
			q[3] = a3 - a2;
		end else begin
			q[0] = 6 * a2 - 6 * a1;
			q[1] = -q[0];
			q[2] = 3 * a2 - 4 * a1 + one;
			q[3] = 3 * a2 - 2 * a1;
		end
		for (int i = 0; i < 4; i++)
			w[i] = q[i][hpe_pkg::WGT_SHIFT +: hpe_pkg::WGT_W];
		return w;
	endfunction

	// request fields
	logic [2:0] cmd;
	logic [1:0] crn;
	logic signed [CW-1:0] vec [3];
	logic [PU-1:0] pu, pv;
	logic accept, is_eval;

	assign cmd = s_axis_tuser[2:0];
	assign crn = s_axis_tuser[4:3];
	always_comb begin
		for (int k = 0; k < 3; k++)
			vec[k] = s_axis_tdata[k*CW +: CW];
	end
	assign pu = s_axis_tdata[3*CW +: PU];
	assign pv = s_axis_tdata[3*CW+PU +: PU];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign is_eval = (cmd == hpe_pkg::CMD_EVAL_POINT) || (cmd == hpe_pkg::CMD_EVAL_DU)
		|| (cmd == hpe_pkg::CMD_EVAL_DV);

	// corner store
	logic signed [CW-1:0] pts_q [4][3];
	logic signed [CW-1:0] der_q [4][2][3];
	logic signed [CW-1:0] nrm_q [4][3];

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 3; k++) begin
				unique case (cmd)
					hpe_pkg::CMD_LOAD_POINT: pts_q[crn][k] <= vec[k];
					hpe_pkg::CMD_LOAD_DU:    der_q[crn][0][k] <= vec[k];
					hpe_pkg::CMD_LOAD_DV:    der_q[crn][1][k] <= vec[k];
					hpe_pkg::CMD_LOAD_NRM:   nrm_q[crn][k] <= vec[k];
					default: ;
				endcase
			end
		end
	end

	// valid chain; a stage advances when empty or when the next one advances
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9, adv10;

	assign adv10 = !valid_s10 || m_axis_tready;
	assign adv9  = !valid_s9 || adv10;
	assign adv8  = !valid_s8 || adv9;
	assign adv7  = !valid_s7 || adv8;
	assign adv6  = !valid_s6 || adv7;
	assign adv5  = !valid_s5 || adv6;
	assign adv4  = !valid_s4 || adv5;
	assign adv3  = !valid_s3 || adv4;
	assign adv2  = !valid_s2 || adv3;
	assign adv1  = !valid_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0; valid_s2 <= 1'b0; valid_s3 <= 1'b0; valid_s4 <= 1'b0;
			valid_s5 <= 1'b0; valid_s6 <= 1'b0; valid_s7 <= 1'b0; valid_s8 <= 1'b0;
			valid_s9 <= 1'b0; valid_s10 <= 1'b0;
		end else begin
			if (adv1)  valid_s1  <= accept && is_eval;
			if (adv2)  valid_s2  <= valid_s1;
			if (adv3)  valid_s3  <= valid_s2;
			if (adv4)  valid_s4  <= valid_s3;
			if (adv5)  valid_s5  <= valid_s4;
			if (adv6)  valid_s6  <= valid_s5;
			if (adv7)  valid_s7  <= valid_s6;
			if (adv8)  valid_s8  <= valid_s7;
			if (adv9)  valid_s9  <= valid_s8;
			if (adv10) valid_s10 <= valid_s9;
		end
	end

	// stage 1: clamp parameters, decode mode
	logic [PU-1:0] u_s1, v_s1;
	logic du_s1, dv_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			u_s1  <= (pu > hpe_pkg::PARAM_ONE) ? hpe_pkg::PARAM_ONE : pu;
			v_s1  <= (pv > hpe_pkg::PARAM_ONE) ? hpe_pkg::PARAM_ONE : pv;
			du_s1 <= (cmd == hpe_pkg::CMD_EVAL_DU);
			dv_s1 <= (cmd == hpe_pkg::CMD_EVAL_DV);
		end
	end

	// stage 2: snapshot store, d*n products, squares
	logic signed [CW-1:0]  pt_s2 [4][3];
	logic signed [CW-1:0]  d_s2 [4][2][3];
	logic signed [CW-1:0]  n_s2 [4][3];
	logic signed [PW2-1:0] dn_s2 [4][2][3];
	logic [PU-1:0] u_s2, v_s2;
	logic [hpe_pkg::SQ_W-1:0] u2_s2, v2_s2;
	logic du_s2, dv_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int c = 0; c < 4; c++) begin
				for (int k = 0; k < 3; k++) begin
					pt_s2[c][k] <= pts_q[c][k];
					n_s2[c][k]  <= nrm_q[c][k];
					for (int r = 0; r < 2; r++) begin
						d_s2[c][r][k]  <= der_q[c][r][k];
						dn_s2[c][r][k] <= PW2'(der_q[c][r][k]) * PW2'(nrm_q[c][k]);
					end
				end
			end
			u_s2  <= u_s1;
			v_s2  <= v_s1;
			u2_s2 <= hpe_pkg::SQ_W'(u_s1 * u_s1);
			v2_s2 <= hpe_pkg::SQ_W'(v_s1 * v_s1);
			du_s2 <= du_s1;
			dv_s2 <= dv_s1;
		end
	end

	// stage 3: dot products, cubes
	logic signed [CW-1:0] pt_s3 [4][3];
	logic signed [CW-1:0] d_s3 [4][2][3];
	logic signed [CW-1:0] n_s3 [4][3];
	logic signed [CW-1:0] dot_s3 [4][2];
	logic [PU-1:0] u_s3, v_s3;
	logic [hpe_pkg::SQ_W-1:0] u2_s3, v2_s3;
	logic [hpe_pkg::CUBE_W-1:0] u3_s3, v3_s3;
	logic du_s3, dv_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			pt_s3 <= pt_s2;
			d_s3  <= d_s2;
			n_s3  <= n_s2;
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 2; r++)
					dot_s3[c][r] <= sat_acc(ACC_W'(dn_s2[c][r][0]) + ACC_W'(dn_s2[c][r][1])
						+ ACC_W'(dn_s2[c][r][2]));
			u_s3  <= u_s2;
			v_s3  <= v_s2;
			u2_s3 <= u2_s2;
			v2_s3 <= v2_s2;
			u3_s3 <= hpe_pkg::CUBE_W'(u2_s2 * u_s2);
			v3_s3 <= hpe_pkg::CUBE_W'(v2_s2 * v_s2);
			du_s3 <= du_s2;
			dv_s3 <= dv_s2;
		end
	end

	// stage 4: dot*n, basis weights
	logic signed [CW-1:0]  pt_s4 [4][3];
	logic signed [CW-1:0]  d_s4 [4][2][3];
	logic signed [PW2-1:0] dn2_s4 [4][2][3];
	hpe_pkg::wgt4_t hu_s4, hv_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			pt_s4 <= pt_s3;
			d_s4  <= d_s3;
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 2; r++)
					for (int k = 0; k < 3; k++)
						dn2_s4[c][r][k] <= PW2'(dot_s3[c][r]) * PW2'(n_s3[c][k]);
			hu_s4 <= basis(u_s3, u2_s3, u3_s3, du_s3);
			hv_s4 <= basis(v_s3, v2_s3, v3_s3, dv_s3);
		end
	end

	// stage 5: project derivatives onto the tangent plane
	logic signed [CW-1:0] pt_s5 [4][3];
	logic signed [CW-1:0] tan_s5 [4][2][3];
	hpe_pkg::wgt4_t hu_s5, hv_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			pt_s5 <= pt_s4;
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 2; r++)
					for (int k = 0; k < 3; k++)
						tan_s5[c][r][k] <= sat_acc((ACC_W'(d_s4[c][r][k]) <<< FRAC_BITS)
							- ACC_W'(dn2_s4[c][r][k]));
			hu_s5 <= hu_s4;
			hv_s5 <= hv_s4;
		end
	end

	// stage 6: weight each entry by its v basis value
	logic signed [CW-1:0] ent [NE][3];
	logic signed [PW-1:0] p_s6 [NE][3];
	hpe_pkg::wgt4_t hu_s6;

	always_comb begin
		for (int e = 0; e < NE; e++)
			for (int k = 0; k < 3; k++)
				ent[e][k] = hpe_pkg::ENT_TAN[e]
					? tan_s5[hpe_pkg::ENT_CRN[e]][hpe_pkg::ENT_DIR[e]][k]
					: pt_s5[hpe_pkg::ENT_CRN[e]][k];
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			for (int e = 0; e < NE; e++)
				for (int k = 0; k < 3; k++)
					p_s6[e][k] <= PW'($signed(hv_s5[hpe_pkg::ENT_J[e]])) * PW'(ent[e][k]);
			hu_s6 <= hu_s5;
		end
	end

	// stage 7: u weighting, split into low and high partial products
	logic signed [PL_W-1:0] pl_s7 [NE][3];
	logic signed [PW-1:0]   ph_s7 [NE][3];

	always_ff @(posedge clk) begin
		if (adv7) begin
			for (int e = 0; e < NE; e++) begin
				for (int k = 0; k < 3; k++) begin
					pl_s7[e][k] <= PL_W'($signed(hu_s6[hpe_pkg::ENT_I[e]]))
						* PL_W'($signed({1'b0, p_s6[e][k][LO_W-1:0]}));
					ph_s7[e][k] <= PW'($signed(hu_s6[hpe_pkg::ENT_I[e]]))
						* PW'($signed(p_s6[e][k][PW-1:LO_W]));
				end
			end
		end
	end

	// stage 8: recombine partial products
	logic signed [SUMW-1:0] prod_s8 [NE][3];

	always_ff @(posedge clk) begin
		if (adv8) begin
			for (int e = 0; e < NE; e++)
				for (int k = 0; k < 3; k++)
					prod_s8[e][k] <= (SUMW'(ph_s7[e][k]) <<< LO_W) + SUMW'(pl_s7[e][k]);
		end
	end

	// stage 9: sum groups of four
	logic signed [SUMW-1:0] grp_s9 [3][3];

	always_ff @(posedge clk) begin
		if (adv9) begin
			for (int g = 0; g < 3; g++)
				for (int k = 0; k < 3; k++)
					grp_s9[g][k] <= prod_s8[4*g][k] + prod_s8[4*g+1][k]
						+ prod_s8[4*g+2][k] + prod_s8[4*g+3][k];
		end
	end

	// stage 10: final sum, floor and saturate; this is the output register
	logic signed [CW-1:0] res_s10 [3];

	always_ff @(posedge clk) begin
		if (adv10) begin
			for (int k = 0; k < 3; k++)
				res_s10[k] <= sat_sum(grp_s9[0][k] + grp_s9[1][k] + grp_s9[2][k]);
		end
	end

	assign m_axis_tvalid = valid_s10;
	assign m_axis_tdata  = OUT_W'({res_s10[2], res_s10[1], res_s10[0]});

endmodule

// ----- design/hpe_checker.sv -----
module hpe_props #(
	parameter int COORD_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// input backs up only when the whole pipe is full behind a stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

	// no result during reset or right after it
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result out of reset");

endmodule

bind hermite_patch_evaluator hpe_props #(.COORD_WIDTH(COORD_WIDTH)) u_hpe_props (.*);
